// File: rtl/bsc_pkg.sv
// Shared constants and types for the barometric sensor compensation unit.
package bsc_pkg;

    localparam int ADC_BITS = 24;
    localparam int ADC_W = 24;
    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((64'd1 << ADC_BITS) - 64'd1);

    localparam int LIMB_W = 32;
    localparam int A_LIMBS = 2;
    localparam int B_LIMBS = 6;
    localparam int PP_N = A_LIMBS * B_LIMBS;
    localparam int MUL_A_W = LIMB_W * A_LIMBS;
    localparam int MUL_B_W = LIMB_W * B_LIMBS;
    localparam int PROD_W = 256;
    localparam int MUL_STAGES = 5;

    localparam int PIPE_N = 24;

    localparam int CAL_BYTES = 21;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    typedef enum logic [1:0] {
        REG_CALIB_LOW  = 2'd0,
        REG_CALIB_MID  = 2'd1,
        REG_CALIB_HIGH = 2'd2
    } reg_index_t;

endpackage

// File: rtl/bsc_if.sv
// Valid/ready channels for raw conversion pairs and compensated results.
interface bsc_sample_if;
    import bsc_pkg::*;
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_pressure;
    logic [ADC_W-1:0] adc_temperature;

    modport source (output valid, output adc_pressure, output adc_temperature, input ready);
    modport sink (input valid, input adc_pressure, input adc_temperature, output ready);
endinterface

interface bsc_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] temperature_q16;
    logic [24:0]        pressure_q8;
    logic               saturated;

    modport source (output valid, output temperature_q16, output pressure_q8, output saturated,
                    input ready);
    modport sink (input valid, input temperature_q16, input pressure_q8, input saturated,
                  output ready);
endinterface

// File: rtl/baro_sensor_compensation_unit.sv
// Top level of the barometric sensor compensation unit.
// Takes one raw pressure/temperature conversion pair per cycle and returns the linearized
// temperature (1/65536 degC, signed 24 bits) and compensated pressure (1/256 Pa, 25 bits),
// both rounded to nearest and clamped, with a flag when either is clamped. The pressure
// polynomial is evaluated in Horner form through three 5-stage 64 x 192 multipliers in
// series. A new beat is taken every cycle while the result side keeps up. Calibration
// bytes are written over the APB port at 0x00, 0x08 and 0x10 and must only change while
// no beat is in flight.
module baro_sensor_compensation_unit import bsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    bsc_sample_if.sink           sample,
    bsc_result_if.source         result
);

    typedef struct packed {
        logic signed [63:0]  nt;
        logic signed [95:0]  c2;
        logic signed [159:0] c1;
        logic [255:0]        c0;
        logic signed [23:0]  tq;
        logic                tsat;
    } side_t;

    logic [63:0] calib_low_reg;
    logic [63:0] calib_mid_reg;
    logic [39:0] calib_high_reg;
    logic [7:0]  cb [CAL_BYTES];

    logic [15:0]        t1, t2, p5, p6;
    logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
    logic signed [15:0] p1, p2, p9;
    logic signed [16:0] p1m, p2m;

    logic [PIPE_N:1]   v_reg;
    logic [PIPE_N+1:1] en;
    logic [PIPE_N:0]   v_in;

    logic [ADC_W-1:0]    ap1_reg, at1_reg;
    logic [ADC_W-1:0]    ap2_reg;
    logic signed [24:0]  d2_reg;
    logic signed [24:0]  d_next;
    logic signed [24:0]  aps;

    logic [ADC_W-1:0]    ap3_reg;
    logic signed [41:0]  m1_reg;
    logic signed [49:0]  dd_reg;
    logic signed [32:0]  p4a_reg, p3a_reg;
    logic signed [41:0]  p2a_reg, p1a_reg;
    logic [47:0]         aa_reg;

    logic signed [57:0]  t3dd;
    logic signed [63:0]  nt4_reg;
    logic [71:0]         aaa4_reg;
    logic signed [64:0]  p9aa4_reg;
    logic signed [56:0]  p10aa4_reg;
    logic signed [33:0]  c3_4_reg, c2p4_reg;
    logic signed [159:0] c1a4_reg;
    logic [255:0]        c0a4_reg;

    logic signed [63:0]  tsum;
    logic signed [31:0]  tqw;
    logic signed [23:0]  tq_next;
    logic                tsat_next;
    logic signed [63:0]  nt5_reg;
    logic signed [33:0]  c3_5_reg;
    logic signed [23:0]  tq5_reg;
    logic                tsat5_reg;
    logic signed [95:0]  c2_5_reg;
    logic signed [159:0] c1_5_reg;
    logic [255:0]        c0b5_reg;
    logic signed [80:0]  m11_5_reg;

    side_t               side_reg [6:PIPE_N-1];
    logic [MUL_B_W-1:0]  x_reg, y_reg;
    logic [PROD_W-1:0]   mp1, mp2, mp3;
    logic [PROD_W-1:0]   n_reg;

    logic signed [23:0]  out_temp_reg;
    logic [24:0]         out_press_reg;
    logic                out_sat_reg;
    logic [24:0]         press_next;
    logic                psat_next;

    // calibration registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_low_reg  <= '0;
            calib_mid_reg  <= '0;
            calib_high_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:3])
                REG_CALIB_LOW:  calib_low_reg  <= pwdata;
                REG_CALIB_MID:  calib_mid_reg  <= pwdata;
                REG_CALIB_HIGH: calib_high_reg <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_CALIB_LOW:  prdata = calib_low_reg;
            REG_CALIB_MID:  prdata = calib_mid_reg;
            REG_CALIB_HIGH: prdata = {24'd0, calib_high_reg};
            default:        prdata = '0;
        endcase
    end

    for (genvar k = 0; k < CAL_BYTES; k++) begin : g_cb
        if (k < 8) begin : g_lo
            assign cb[k] = calib_low_reg[8*k +: 8];
        end
        else if (k < 16) begin : g_mid
            assign cb[k] = calib_mid_reg[8*(k-8) +: 8];
        end
        else begin : g_hi
            assign cb[k] = calib_high_reg[8*(k-16) +: 8];
        end
    end

    assign t1  = {cb[1], cb[0]};
    assign t2  = {cb[3], cb[2]};
    assign t3  = $signed(cb[4]);
    assign p1  = $signed({cb[6], cb[5]});
    assign p2  = $signed({cb[8], cb[7]});
    assign p3  = $signed(cb[9]);
    assign p4  = $signed(cb[10]);
    assign p5  = {cb[12], cb[11]};
    assign p6  = {cb[14], cb[13]};
    assign p7  = $signed(cb[15]);
    assign p8  = $signed(cb[16]);
    assign p9  = $signed({cb[18], cb[17]});
    assign p10 = $signed(cb[19]);
    assign p11 = $signed(cb[20]);
    assign p1m = 17'(p1) - 17'sd16384;
    assign p2m = 17'(p2) - 17'sd16384;

    // flow control: a stage advances when it is empty or its successor advances
    assign en[PIPE_N+1] = result.ready;
    for (genvar k = 1; k <= PIPE_N; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end
    assign v_in = {v_reg, sample.valid};
    assign sample.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= PIPE_N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_in[k-1];
                end
            end
        end
    end

    // temperature difference and the small products
    assign d_next = $signed({1'b0, at1_reg}) - $signed({1'b0, t1, 8'h00});
    assign aps    = $signed({1'b0, ap2_reg});
    assign t3dd   = t3 * dd_reg;

    // temperature rounding and clamp
    assign tsum = nt4_reg + 64'sd2147483648;
    assign tqw  = tsum[63:32];

    always_comb
    begin
        tsat_next = 1'b0;
        tq_next   = tqw[23:0];
        if (tqw > 32'sd8388607)
        begin
            tq_next   = 24'sh7FFFFF;
            tsat_next = 1'b1;
        end
        else if (tqw < -32'sd8388608)
        begin
            tq_next   = 24'sh800000;
            tsat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ap1_reg <= sample.adc_pressure & ADC_MASK;
            at1_reg <= sample.adc_temperature & ADC_MASK;
        end
        if (en[2])
        begin
            ap2_reg <= ap1_reg;
            d2_reg  <= d_next;
        end
        if (en[3])
        begin
            ap3_reg <= ap2_reg;
            m1_reg  <= $signed({1'b0, t2}) * d2_reg;
            dd_reg  <= d2_reg * d2_reg;
            p4a_reg <= p4 * aps;
            p3a_reg <= p3 * aps;
            p2a_reg <= p2m * aps;
            p1a_reg <= p1m * aps;
            aa_reg  <= ap2_reg * ap2_reg;
        end
        if (en[4])
        begin
            nt4_reg    <= (64'(m1_reg) <<< 18) + 64'(t3dd);
            aaa4_reg   <= aa_reg * ap3_reg;
            p9aa4_reg  <= p9 * $signed({1'b0, aa_reg});
            p10aa4_reg <= p10 * $signed({1'b0, aa_reg});
            c3_4_reg   <= (34'(p8) <<< 22) + 34'(p4a_reg);
            c2p4_reg   <= (34'(p7) <<< 24) + 34'(p3a_reg);
            c1a4_reg   <= (160'($signed({1'b0, p6})) <<< 127) + (160'(p2a_reg) <<< 104);
            c0a4_reg   <= ((256'(p5) << 184) | (256'd1 << 172)) + (256'(p1a_reg) << 161);
        end
        if (en[5])
        begin
            nt5_reg   <= nt4_reg;
            c3_5_reg  <= c3_4_reg;
            tq5_reg   <= tq_next;
            tsat5_reg <= tsat_next;
            c2_5_reg  <= 96'(c2p4_reg) <<< 53;
            c1_5_reg  <= c1a4_reg + (160'(p10aa4_reg) <<< 85);
            c0b5_reg  <= c0a4_reg + (256'(p9aa4_reg) << 133);
            m11_5_reg <= p11 * $signed({1'b0, aaa4_reg});
        end
        if (en[6])
        begin
            side_reg[6].nt   <= nt5_reg;
            side_reg[6].c2   <= c2_5_reg;
            side_reg[6].c1   <= c1_5_reg;
            side_reg[6].c0   <= c0b5_reg + (256'(m11_5_reg) << 116);
            side_reg[6].tq   <= tq5_reg;
            side_reg[6].tsat <= tsat5_reg;
        end
        for (int k = 7; k <= PIPE_N - 1; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        if (en[11])
        begin
            x_reg <= mp1[MUL_B_W-1:0] + MUL_B_W'(side_reg[10].c2);
        end
        if (en[17])
        begin
            y_reg <= mp2[MUL_B_W-1:0] + MUL_B_W'(side_reg[16].c1);
        end
        if (en[23])
        begin
            n_reg <= mp3 + side_reg[22].c0;
        end
        if (en[24])
        begin
            out_temp_reg  <= side_reg[23].tq;
            out_press_reg <= press_next;
            out_sat_reg   <= side_reg[23].tsat | psat_next;
        end
    end

    // Horner steps in the temperature term
    bsc_mul u_mul1 (
        .clk (clk),
        .en  (en[10:6]),
        .a   (nt5_reg),
        .b   (MUL_B_W'(c3_5_reg)),
        .p   (mp1)
    );

    bsc_mul u_mul2 (
        .clk (clk),
        .en  (en[16:12]),
        .a   (side_reg[11].nt),
        .b   ($signed(x_reg)),
        .p   (mp2)
    );

    bsc_mul u_mul3 (
        .clk (clk),
        .en  (en[22:18]),
        .a   (side_reg[17].nt),
        .b   ($signed(y_reg)),
        .p   (mp3)
    );

    // pressure extraction and clamp
    always_comb
    begin
        psat_next  = 1'b0;
        press_next = n_reg[197:173];
        if (n_reg[255])
        begin
            press_next = '0;
            psat_next  = 1'b1;
        end
        else if (|n_reg[254:198])
        begin
            press_next = '1;
            psat_next  = 1'b1;
        end
    end

    assign result.valid           = v_reg[PIPE_N];
    assign result.temperature_q16 = out_temp_reg;
    assign result.pressure_q8     = out_press_reg;
    assign result.saturated       = out_sat_reg;

endmodule

// File: rtl/bsc_mul.sv
// Pipelined signed 64 x 192 multiplier built from 33 x 33 limb products.
module bsc_mul import bsc_pkg::*;
(
    input  logic                       clk,
    input  logic [MUL_STAGES-1:0]      en,
    input  logic signed [MUL_A_W-1:0]  a,
    input  logic signed [MUL_B_W-1:0]  b,
    output logic [PROD_W-1:0]          p
);

    logic signed [2*LIMB_W+1:0] pp_reg [PP_N];
    logic [PROD_W-1:0]          ppx [PP_N];
    logic [PROD_W-1:0]          l1_reg [PP_N/2];
    logic [PROD_W-1:0]          l2_reg [3];
    logic [PROD_W-1:0]          l3_reg [2];
    logic [PROD_W-1:0]          l4_reg;

    for (genvar gi = 0; gi < A_LIMBS; gi++) begin : g_a
        for (genvar gj = 0; gj < B_LIMBS; gj++) begin : g_b
            logic signed [LIMB_W:0] al;
            logic signed [LIMB_W:0] bl;

            assign al = (gi == A_LIMBS - 1)
                ? $signed({a[LIMB_W*gi+LIMB_W-1], a[LIMB_W*gi +: LIMB_W]})
                : $signed({1'b0, a[LIMB_W*gi +: LIMB_W]});
            assign bl = (gj == B_LIMBS - 1)
                ? $signed({b[LIMB_W*gj+LIMB_W-1], b[LIMB_W*gj +: LIMB_W]})
                : $signed({1'b0, b[LIMB_W*gj +: LIMB_W]});
            assign ppx[gi*B_LIMBS+gj] = PROD_W'(pp_reg[gi*B_LIMBS+gj]) << (LIMB_W*(gi+gj));

            always_ff @(posedge clk)
            begin
                if (en[0])
                begin
                    pp_reg[gi*B_LIMBS+gj] <= al * bl;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PP_N/2; k++)
        begin
            if (en[1])
            begin
                l1_reg[k] <= ppx[2*k] + ppx[2*k+1];
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (en[2])
            begin
                l2_reg[k] <= l1_reg[2*k] + l1_reg[2*k+1];
            end
        end
        if (en[3])
        begin
            l3_reg[0] <= l2_reg[0] + l2_reg[1];
            l3_reg[1] <= l2_reg[2];
        end
        if (en[4])
        begin
            l4_reg <= l3_reg[0] + l3_reg[1];
        end
    end

    assign p = l4_reg;

endmodule

// File: dv/tb_baro_sensor_compensation_unit.sv
// Self-checking testbench for the barometric sensor compensation unit.
`timescale 1ns / 1ps

class baro_scoreboard;
    typedef logic signed [255:0] wide_t;
    typedef struct packed {
        logic [23:0] temperature_q16;
        logic [24:0] pressure_q8;
        logic        saturated;
    } comp_t;

    logic [167:0] cal;
    comp_t        expected_q[$];
    int           errors;

    function new();
        cal = '0;
        errors = 0;
    endfunction

    function void set_reg(int idx, logic [63:0] value);
        if (idx == 0) cal[63:0] = value;
        else if (idx == 1) cal[127:64] = value;
        else if (idx == 2) cal[167:128] = value[39:0];
    endfunction

    function longint u16(int k);
        u16 = {48'd0, cal[8*k+8 +: 8], cal[8*k +: 8]};
    endfunction

    function longint s16(int k);
        s16 = {{48{cal[8*k+15]}}, cal[8*k+8 +: 8], cal[8*k +: 8]};
    endfunction

    function longint s8(int k);
        s8 = {{56{cal[8*k+7]}}, cal[8*k +: 8]};
    endfunction

    function wide_t term(longint coef, wide_t f, int sh);
        wide_t c;
        c = coef;
        term = (c * f) << sh;
    endfunction

    function void note(logic [23:0] adc_p, logic [23:0] adc_t);
        longint d, nt, tq;
        wide_t  tv, tt, ttt, av, aa, aaa, one, n;
        comp_t  e;
        e.saturated = 1'b0;
        d = longint'(adc_t) - u16(0) * 256;
        nt = u16(2) * d * 262144 + s8(4) * d * d;
        tq = (nt + 64'sd2147483648) >>> 32;
        if (tq > 8388607) begin tq = 8388607; e.saturated = 1'b1; end
        if (tq < -8388608) begin tq = -8388608; e.saturated = 1'b1; end
        e.temperature_q16 = tq[23:0];
        tv = nt;
        tt = tv * tv;
        ttt = tt * tv;
        av = {232'd0, adc_p};
        aa = av * av;
        aaa = aa * av;
        one = 1;
        n = term(u16(11), one, 184);
        n = n + term(u16(13), tv, 127);
        n = n + term(s8(15), tt, 77);
        n = n + term(s8(16), ttt, 22);
        n = n + term(s16(5) - 16384, av, 161);
        n = n + term(s16(7) - 16384, av * tv, 104);
        n = n + term(s8(9), av * tt, 53);
        n = n + term(s8(10), av * ttt, 0);
        n = n + term(s16(17), aa, 133);
        n = n + term(s8(19), aa * tv, 85);
        n = n + term(s8(20), aaa, 116);
        n = n + (one << 172);
        if (n[255]) begin
            e.pressure_q8 = '0;
            e.saturated = 1'b1;
        end else if (|n[255:198]) begin
            e.pressure_q8 = '1;
            e.saturated = 1'b1;
        end else begin
            e.pressure_q8 = n[197:173];
        end
        expected_q.push_back(e);
    endfunction

    function void check(logic [23:0] temp, logic [24:0] pres, logic sat);
        comp_t e;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat: t=%h p=%h s=%b", temp, pres, sat);
            return;
        end
        e = expected_q.pop_front();
        if (e.temperature_q16 !== temp || e.pressure_q8 !== pres || e.saturated !== sat) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected t=%h p=%h s=%b, got t=%h p=%h s=%b",
                         e.temperature_q16, e.pressure_q8, e.saturated, temp, pres, sat);
        end
    endfunction

    function int pending();
        pending = expected_q.size();
    endfunction
endclass

module tb_baro_sensor_compensation_unit;
    import bsc_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bsc_sample_if smp();
    bsc_result_if res();

    baro_scoreboard comp_sb;
    int             send_pct;
    int             stall_pct;
    int             quiet_cycles;

    baro_sensor_compensation_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (smp.sink),
        .result  (res.source)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        res.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            comp_sb.check(res.temperature_q16, res.pressure_q8, res.saturated);
        if (rst_n && ((res.valid && res.ready) || (smp.valid && smp.ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 20000)
        begin
            $display("** baro_sensor_compensation_unit: FAILED **");
            $finish;
        end
    end

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        while (comp_sb.pending() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic load_calib(logic [167:0] c);
        drain();
        apb_write(5'(8 * REG_CALIB_LOW), c[63:0]);
        comp_sb.set_reg(REG_CALIB_LOW, c[63:0]);
        apb_write(5'(8 * REG_CALIB_MID), c[127:64]);
        comp_sb.set_reg(REG_CALIB_MID, c[127:64]);
        apb_write(5'(8 * REG_CALIB_HIGH), {24'($urandom), c[167:128]});
        comp_sb.set_reg(REG_CALIB_HIGH, {24'd0, c[167:128]});
        apb_write(5'd24, {$urandom, $urandom});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send(logic [23:0] adc_p, logic [23:0] adc_t);
        while ($urandom_range(99) < send_pct)
        begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid <= 1'b1;
        smp.adc_pressure <= adc_p;
        smp.adc_temperature <= adc_t;
        @(posedge clk);
        while (!smp.ready) @(posedge clk);
        comp_sb.note(adc_p, adc_t);
        @(negedge clk);
    endtask

    task automatic set_idle(int mode);
        case (mode % 4)
            0: begin send_pct = 0; stall_pct = 0; end
            1: begin send_pct = 76; stall_pct = 0; end
            2: begin send_pct = 0; stall_pct = 76; end
            default: begin send_pct = 18; stall_pct = 18; end
        endcase
    endtask

    function automatic logic [167:0] gentle_calib();
        logic [167:0] c;
        logic [15:0]  p1, p2;
        c = '0;
        p1 = 16'(16384 + $urandom_range(127) - 64);
        p2 = 16'(16384 + $urandom_range(127) - 64);
        c[15:0] = 16'($urandom);
        c[31:16] = 16'($urandom);
        c[39:32] = 8'($urandom_range(15) - 8);
        c[55:40] = p1;
        c[71:56] = p2;
        c[79:72] = 8'($urandom_range(7) - 4);
        c[87:80] = 8'($urandom_range(7) - 4);
        c[103:88] = 16'($urandom_range(16000, 2000));
        c[119:104] = 16'($urandom);
        c[127:120] = 8'($urandom_range(7) - 4);
        c[135:128] = 8'($urandom_range(7) - 4);
        c[151:136] = 16'($urandom_range(7) - 4);
        c[159:152] = 8'($urandom_range(7) - 4);
        c[167:160] = 8'($urandom_range(7) - 4);
        return c;
    endfunction

    task automatic random_items(int count);
        logic [23:0] t_mid;
        t_mid = {comp_sb.cal[15:0], 8'd0};
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(1))
                send(24'($urandom), 24'($urandom));
            else
                send(24'($urandom), 24'(t_mid + $urandom_range(2000000) - 1000000));
            if (i == count / 2 && $urandom_range(1))
                drain();
        end
    endtask

    initial
    begin
        logic [167:0] c;
        comp_sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        smp.valid = 1'b0;
        smp.adc_pressure = '0;
        smp.adc_temperature = '0;
        res.ready = 1'b0;
        send_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(24'd0, 24'd0);
        send(24'hFFFFFF, 24'hFFFFFF);

        load_calib('1);
        send(24'd0, 24'd0);
        send(24'hFFFFFF, 24'hFFFFFF);
        send(24'hFFFFFF, 24'hFFFF00);
        send(24'h000000, 24'h800000);

        c = gentle_calib();
        load_calib(c);
        send(24'd0, {c[15:0], 8'd0});
        send(24'hFFFFFF, {c[15:0], 8'd0});
        send(24'h800000, {c[15:0], 8'd0} + 24'd1);
        send(24'h7FFFFF, {c[15:0], 8'd0} - 24'd1);
        send(24'h555555, 24'hAAAAAA);
        send(24'hAAAAAA, 24'h555555);
        send(24'h000001, 24'h000000);
        send(24'hFFFFFF, 24'h000000);
        send(24'h000000, 24'hFFFFFF);

        c = '0;
        c[103:88] = 16'hFFFF;
        c[119:104] = 16'hFFFF;
        load_calib(c);
        send(24'd0, 24'hFFFFFF);
        send(24'hFFFFFF, 24'hFFFFFF);

        c = '0;
        c[55:40] = 16'h8000;
        c[71:56] = 16'h8000;
        load_calib(c);
        send(24'hFFFFFF, 24'hFFFFFF);
        send(24'hFFFFFF, 24'h000000);

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 4 || ph == 8)
                c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            else if (ph == 7)
                c = '0;
            else
                c = gentle_calib();
            load_calib(c);
            set_idle(ph);
            random_items(66);
        end

        send_pct = 0;
        stall_pct = 0;
        drain();
        if (comp_sb.errors == 0)
            $display("** baro_sensor_compensation_unit: PASSED **");
        else
            $display("** baro_sensor_compensation_unit: FAILED **");
        $finish;
    end
endmodule
